### hdl/rots_pkg.sv
package rots_pkg;

    localparam int TICK_W     = 16;
    localparam int RATE_W     = 24;
    localparam int TRIM_W     = 8;
    localparam int ERR_W      = 16;
    localparam int CFG_IDX_W  = 1;

    localparam int TICK_SCALE    = 8;
    localparam int PERCENT_SCALE = 10000;
    // |stop - start| * 80000 needs 33 bits
    localparam int PROD_W = TICK_W + $clog2(TICK_SCALE * PERCENT_SCALE);

    localparam logic signed [ERR_W-1:0] ERR_INVALID = 16'sh7FFF;
    // largest quotient that does not saturate: 32767 + 10000
    localparam logic [PROD_W-1:0] Q_SAT_LIMIT = PROD_W'(32767 + PERCENT_SCALE);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(250000);
    localparam logic [TRIM_W-1:0] TRIM_RESET = TRIM_W'(128);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RATE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TRIM = 1'b1;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### hdl/rc_oscillator_trim_search.sv
// Start items and measurements while idle: result word registered in the cycle after accept.
// Measurements while searching: the result passes the divider, ST_SAT and ST_DEC; the bit-serial
// divider takes one quotient bit per cycle over the 33-bit product.
// One item at a time, taken once the result register is free or being read: no new
// word is taken while a search measurement is in progress, other words every cycle.
// aresetn (synchronous): timer_rate 250000, initial_trim 128, search idle,
// best error 32767, best trim 0, current trim 128.
module rc_oscillator_trim_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [rots_pkg::TICK_W-1:0]         s_start_tick,
    input  logic [rots_pkg::TICK_W-1:0]         s_stop_tick,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rots_pkg::TRIM_W-1:0]         m_trim_out,
    output logic signed [rots_pkg::ERR_W-1:0]   m_error_out,
    output logic                                m_finished,
    output logic                                m_result_valid,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rots_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rots_pkg::RATE_W-1:0]         cfg_data
);
    import rots_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam logic [1:0] ST_DEC  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [RATE_W-1:0]       timer_rate_reg;
    logic [TRIM_W-1:0]       initial_trim_reg;
    logic                    searching_reg, searching_next;
    logic signed [ERR_W-1:0] best_error_reg, best_error_next;
    logic [TRIM_W-1:0]       best_trim_reg, best_trim_next;
    logic [TRIM_W-1:0]       cur_trim_reg, cur_trim_next;
    logic signed [ERR_W-1:0] err_reg, err_next;

    logic                    m_valid_reg, m_valid_next;
    logic [TRIM_W-1:0]       trim_out_reg, trim_out_next;
    logic signed [ERR_W-1:0] error_out_reg, error_out_next;
    logic                    finished_reg, finished_next;
    logic                    res_valid_reg, res_valid_next;

    logic                    out_free;
    logic                    s_fire;
    logic                    div_start;
    logic [TICK_W-1:0]       tick_diff;
    logic [PROD_W-1:0]       product;
    logic [RATE_W-1:0]       rate_eff;
    logic [PROD_W-1:0]       quotient;
    div_stat_t               div_stat;
    logic [ERR_W-1:0]        abs_err;
    logic [ERR_W-1:0]        abs_best;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign tick_diff = (s_stop_tick >= s_start_tick) ? (s_stop_tick - s_start_tick)
                                                     : (s_start_tick - s_stop_tick);
    assign product   = {{(PROD_W-TICK_W){1'b0}}, tick_diff}
                       * PROD_W'(TICK_SCALE * PERCENT_SCALE);
    assign rate_eff  = (timer_rate_reg == '0) ? RATE_W'(1) : timer_rate_reg;
    assign div_start = s_fire && (s_opcode == OP_MEASURE) && searching_reg;

    rots_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (RATE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (rate_eff),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // err never goes below -10000, so negation cannot overflow
    assign abs_err  = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign abs_best = best_error_reg[ERR_W-1] ? ERR_W'(-best_error_reg)
                                              : ERR_W'(best_error_reg);

    always_comb begin
        state_next      = state_reg;
        searching_next  = searching_reg;
        best_error_next = best_error_reg;
        best_trim_next  = best_trim_reg;
        cur_trim_next   = cur_trim_reg;
        err_next        = err_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        trim_out_next   = trim_out_reg;
        error_out_next  = error_out_reg;
        finished_next   = finished_reg;
        res_valid_next  = res_valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == OP_START) begin
                        cur_trim_next   = initial_trim_reg;
                        best_trim_next  = initial_trim_reg;
                        best_error_next = ERR_INVALID;
                        searching_next  = 1'b1;
                        m_valid_next    = 1'b1;
                        trim_out_next   = initial_trim_reg;
                        error_out_next  = ERR_INVALID;
                        finished_next   = 1'b0;
                        res_valid_next  = 1'b0;
                    end else if (searching_reg) begin
                        state_next = ST_DIV;
                    end else begin
                        m_valid_next   = 1'b1;
                        trim_out_next  = cur_trim_reg;
                        error_out_next = ERR_INVALID;
                        finished_next  = 1'b0;
                        res_valid_next = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                if (quotient > Q_SAT_LIMIT) begin
                    err_next = ERR_INVALID;
                end else begin
                    err_next = ERR_W'(quotient[ERR_W:0] - (ERR_W+1)'(PERCENT_SCALE));
                end
                state_next = ST_DEC;
            end
            ST_DEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (abs_err < abs_best) begin
                        best_error_next = err_reg;
                        best_trim_next  = cur_trim_reg;
                        cur_trim_next   = (err_reg > 0) ? cur_trim_reg - TRIM_W'(1)
                                                        : cur_trim_reg + TRIM_W'(1);
                        trim_out_next   = cur_trim_next;
                        error_out_next  = ERR_INVALID;
                        finished_next   = 1'b0;
                        res_valid_next  = 1'b0;
                    end else begin
                        cur_trim_next  = best_trim_reg;
                        searching_next = 1'b0;
                        trim_out_next  = best_trim_reg;
                        error_out_next = err_reg;
                        finished_next  = 1'b1;
                        res_valid_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            timer_rate_reg   <= RATE_RESET;
            initial_trim_reg <= TRIM_RESET;
            searching_reg    <= 1'b0;
            best_error_reg   <= ERR_INVALID;
            best_trim_reg    <= '0;
            cur_trim_reg     <= TRIM_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            searching_reg  <= searching_next;
            best_error_reg <= best_error_next;
            best_trim_reg  <= best_trim_next;
            cur_trim_reg   <= cur_trim_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_TIMER_RATE:   timer_rate_reg   <= cfg_data;
                    CFG_INITIAL_TRIM: initial_trim_reg <= cfg_data[TRIM_W-1:0];
                    default: ;
                endcase
            end
        end
        err_reg       <= err_next;
        trim_out_reg  <= trim_out_next;
        error_out_reg <= error_out_next;
        finished_reg  <= finished_next;
        res_valid_reg <= res_valid_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_trim_out     = trim_out_reg;
    assign m_error_out    = error_out_reg;
    assign m_finished     = finished_reg;
    assign m_result_valid = res_valid_reg;

    a_ready_not_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("input accepted while divider busy");

    a_done_to_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |=> (state_reg == ST_SAT))
        else $error("divider result not picked up");

    a_finish_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(searching_reg) && $past(aresetn)) |-> (m_valid && m_finished && m_result_valid))
        else $error("search ended without a final word");

    a_start_only_searching: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> searching_reg && (state_reg == ST_IDLE))
        else $error("divide started outside a search");

endmodule

### hdl/rots_div.sv
module rots_div #(
    parameter int DIVIDEND_W = rots_pkg::PROD_W,
    parameter int DIVISOR_W  = rots_pkg::RATE_W
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output logic [DIVIDEND_W-1:0]   quotient,
    output rots_pkg::div_stat_t     stat
);
    import rots_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
